/* rtl/shape_pair_collision_test_core_defines.svh */
// Assertion macros shared by the shape pair collision test RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef SHAPE_PAIR_COLLISION_TEST_CORE_DEFINES_SVH
`define SHAPE_PAIR_COLLISION_TEST_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SPCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A cause followed by its effect after the delay given by dly.
`define SPCT_ASSERT_LATER(label, cause, dly, effect, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |-> ##dly (effect)) else $error(msg);

`endif

/* rtl/spct_pkg.sv */
// Shared types and widths for the shape pair collision test pipeline.
// No dependencies; imported by every stage module and the top level.
package spct_pkg;

  // Coordinate field width (signed Q12.4 positions, unsigned Q12.4 extents)
  localparam int COORD_BITS = 16;
  localparam int TAG_W      = 16;
  // Doubled coordinates and box bounds, signed
  localparam int DBL_W      = COORD_BITS + 2;
  // Per-axis distance and doubled radius, unsigned
  localparam int MAG_W      = COORD_BITS + 2;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 1;
  // Sum of two extents
  localparam int EXT_W      = COORD_BITS + 1;
  // Pipeline depth from start to result strobe
  localparam int LATENCY    = 4;

  typedef enum logic [1:0] {
    KIND_CC = 2'd0,  // circle - circle
    KIND_CR = 2'd1,  // circle A - box B
    KIND_RC = 2'd2,  // box A - circle B
    KIND_RR = 2'd3   // box - box
  } kind_e;

  // After operand setup: point and interval per axis
  typedef struct packed {
    kind_e                   kind;
    logic signed [DBL_W-1:0] cx;
    logic signed [DBL_W-1:0] cy;
    logic signed [DBL_W-1:0] lox;
    logic signed [DBL_W-1:0] hix;
    logic signed [DBL_W-1:0] loy;
    logic signed [DBL_W-1:0] hiy;
    logic [MAG_W-1:0]        rad;
    logic [EXT_W-1:0]        sumx;
    logic [EXT_W-1:0]        sumy;
    logic [TAG_W-1:0]        tag;
  } setup_t;

  // After distance: per-axis distance from point to interval
  typedef struct packed {
    kind_e             kind;
    logic [MAG_W-1:0]  dx;
    logic [MAG_W-1:0]  dy;
    logic [MAG_W-1:0]  rad;
    logic [EXT_W-1:0]  sumx;
    logic [EXT_W-1:0]  sumy;
    logic [TAG_W-1:0]  tag;
  } dist_t;

endpackage

/* rtl/spct_setup.sv */
// Stage 1: doubles coordinates and picks the point, interval and radius per kind.
// Depends on spct_pkg.
module spct_setup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [1:0]                          kind_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_x_a_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_y_a_i,
  input  logic [spct_pkg::COORD_BITS-1:0]     extent_x_a_i,
  input  logic [spct_pkg::COORD_BITS-1:0]     extent_y_a_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_x_b_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_y_b_i,
  input  logic [spct_pkg::COORD_BITS-1:0]     extent_x_b_i,
  input  logic [spct_pkg::COORD_BITS-1:0]     extent_y_b_i,
  input  logic [spct_pkg::TAG_W-1:0]          pair_tag_i,
  output logic                                valid_o,
  output spct_pkg::setup_t                    data_o
);
  import spct_pkg::*;

  logic signed [DBL_W-1:0] xa2, ya2, xb2, yb2;
  logic signed [DBL_W-1:0] eax, eay, ebx, eby;
  logic [EXT_W-1:0]        sum_ex, sum_ey;
  kind_e                   kind;
  setup_t                  data_d, data_q;
  logic                    valid_q;

  // Doubled positions make half extents exact
  assign xa2 = {pos_x_a_i[COORD_BITS-1], pos_x_a_i, 1'b0};
  assign ya2 = {pos_y_a_i[COORD_BITS-1], pos_y_a_i, 1'b0};
  assign xb2 = {pos_x_b_i[COORD_BITS-1], pos_x_b_i, 1'b0};
  assign yb2 = {pos_y_b_i[COORD_BITS-1], pos_y_b_i, 1'b0};
  assign eax = {2'b00, extent_x_a_i};
  assign eay = {2'b00, extent_y_a_i};
  assign ebx = {2'b00, extent_x_b_i};
  assign eby = {2'b00, extent_y_b_i};
  assign sum_ex = {1'b0, extent_x_a_i} + {1'b0, extent_x_b_i};
  assign sum_ey = {1'b0, extent_y_a_i} + {1'b0, extent_y_b_i};
  assign kind   = kind_e'(kind_i);

  // Operand select: center tests use a degenerate interval at the other center
  always_comb begin
    data_d      = '0;
    data_d.kind = kind;
    data_d.sumx = sum_ex;
    data_d.sumy = sum_ey;
    data_d.tag  = pair_tag_i;
    data_d.cx   = xa2;
    data_d.cy   = ya2;
    data_d.lox  = xb2;
    data_d.hix  = xb2;
    data_d.loy  = yb2;
    data_d.hiy  = yb2;
    data_d.rad  = {sum_ex, 1'b0};
    unique case (kind)
      KIND_CR: begin
        data_d.lox = xb2 - ebx;
        data_d.hix = xb2 + ebx;
        data_d.loy = yb2 - eby;
        data_d.hiy = yb2 + eby;
        data_d.rad = {1'b0, extent_x_a_i, 1'b0};
      end
      KIND_RC: begin
        data_d.cx  = xb2;
        data_d.cy  = yb2;
        data_d.lox = xa2 - eax;
        data_d.hix = xa2 + eax;
        data_d.loy = ya2 - eay;
        data_d.hiy = ya2 + eay;
        data_d.rad = {1'b0, extent_x_b_i, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/spct_dist.sv */
// Stage 2: per-axis distance from the point to its interval (clamp and subtract).
// Depends on spct_pkg.
module spct_dist (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  spct_pkg::setup_t data_i,
  output logic             valid_o,
  output spct_pkg::dist_t  data_o
);
  import spct_pkg::*;

  dist_t data_d, data_q;
  logic  valid_q;

  // Zero inside the interval, else the gap to the nearer bound
  function automatic logic [MAG_W-1:0] gap(input logic signed [DBL_W-1:0] c,
                                           input logic signed [DBL_W-1:0] lo,
                                           input logic signed [DBL_W-1:0] hi);
    logic signed [DBL_W:0] above;
    logic signed [DBL_W:0] below;
    above = {c[DBL_W-1], c} - {hi[DBL_W-1], hi};
    below = {lo[DBL_W-1], lo} - {c[DBL_W-1], c};
    if (c > hi) begin
      gap = above[MAG_W-1:0];
    end else if (c < lo) begin
      gap = below[MAG_W-1:0];
    end else begin
      gap = '0;
    end
  endfunction

  always_comb begin
    data_d.kind = data_i.kind;
    data_d.dx   = gap(data_i.cx, data_i.lox, data_i.hix);
    data_d.dy   = gap(data_i.cy, data_i.loy, data_i.hiy);
    data_d.rad  = data_i.rad;
    data_d.sumx = data_i.sumx;
    data_d.sumy = data_i.sumy;
    data_d.tag  = data_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/spct_judge.sv */
// Stages 3 and 4: squares and box overlap, then squared-distance compare.
// Depends on spct_pkg.
module spct_judge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  spct_pkg::dist_t            data_i,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [spct_pkg::TAG_W-1:0] tag_o
);
  import spct_pkg::*;

  logic [SQ_W-1:0]  sqx_d, sqy_d, sqr_d;
  logic [SQ_W-1:0]  sqx_q, sqy_q, sqr_q;
  logic             rr_d, rr_q;
  kind_e            kind_q;
  logic [TAG_W-1:0] tag3_q, tag4_q;
  logic             valid3_q, valid4_q;
  logic [SUM_W-1:0] dist_sq;
  logic [SUM_W-1:0] rad_sq;
  logic             hit_d, hit_q;

  // Stage 3: squares and box-box per-axis overlap
  assign sqx_d = data_i.dx * data_i.dx;
  assign sqy_d = data_i.dy * data_i.dy;
  assign sqr_d = data_i.rad * data_i.rad;
  assign rr_d  = (data_i.dx <= {1'b0, data_i.sumx}) && (data_i.dy <= {1'b0, data_i.sumy});

  // Stage 4: distance squared against radius squared
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rad_sq  = {1'b0, sqr_q};

  always_comb begin
    case (kind_q)
      KIND_CC: hit_d = dist_sq <= rad_sq;
      KIND_RR: hit_d = rr_q;
      default: hit_d = dist_sq < rad_sq;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      sqr_q  <= sqr_d;
      rr_q   <= rr_d;
      kind_q <= data_i.kind;
      tag3_q <= data_i.tag;
    end
    if (valid3_q) begin
      hit_q  <= hit_d;
      tag4_q <= tag3_q;
    end
  end

  assign valid_o = valid4_q;
  assign hit_o   = hit_q;
  assign tag_o   = tag4_q;

endmodule

/* rtl/shape_pair_collision_test_core.sv */
// Shape pair collision test: one circle/box pair per transaction, four-stage pipeline.
// Depends on spct_pkg, spct_setup, spct_dist, spct_judge and the defines header.
//
// A transaction is taken on every clock edge with start_i high; busy_o is always
// low, so a new pair may be issued every cycle. Each result appears for one cycle,
// with done_o high, once it has passed setup, per-axis clamp distance, squaring,
// and the final compare, which each take one register stage. The receiver cannot
// stall the pipeline and must take hit_o and tag_out_o while done_o is high. No
// state is kept between transactions; reset only clears the valid bits.
`include "shape_pair_collision_test_core_defines.svh"

module shape_pair_collision_test_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             kind_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_x_a_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_y_a_i,
  input  logic [spct_pkg::COORD_BITS-1:0]        extent_x_a_i,
  input  logic [spct_pkg::COORD_BITS-1:0]        extent_y_a_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_x_b_i,
  input  logic signed [spct_pkg::COORD_BITS-1:0] pos_y_b_i,
  input  logic [spct_pkg::COORD_BITS-1:0]        extent_x_b_i,
  input  logic [spct_pkg::COORD_BITS-1:0]        extent_y_b_i,
  input  logic [spct_pkg::TAG_W-1:0]             pair_tag_i,
  output logic                                   done_o,
  output logic                                   hit_o,
  output logic [spct_pkg::TAG_W-1:0]             tag_out_o
);
  import spct_pkg::*;

  logic   accept;
  logic   s1_valid, s2_valid;
  setup_t s1_data;
  dist_t  s2_data;
  logic   same_center;
  logic   cc_same, rr_same;

  // Pipeline never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  spct_setup u_setup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .kind_i       (kind_i),
    .pos_x_a_i    (pos_x_a_i),
    .pos_y_a_i    (pos_y_a_i),
    .extent_x_a_i (extent_x_a_i),
    .extent_y_a_i (extent_y_a_i),
    .pos_x_b_i    (pos_x_b_i),
    .pos_y_b_i    (pos_y_b_i),
    .extent_x_b_i (extent_x_b_i),
    .extent_y_b_i (extent_y_b_i),
    .pair_tag_i   (pair_tag_i),
    .valid_o      (s1_valid),
    .data_o       (s1_data)
  );

  spct_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  spct_judge u_judge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (done_o),
    .hit_o   (hit_o),
    .tag_o   (tag_out_o)
  );

  // Both shapes share one center
  assign same_center = (pos_x_a_i == pos_x_b_i) && (pos_y_a_i == pos_y_b_i);
  assign cc_same     = accept && (kind_i == KIND_CC) && same_center;
  assign rr_same     = accept && (kind_i == KIND_RR) && same_center;

  // Every accepted transaction yields exactly one strobe after the pipeline depth
  `SPCT_ASSERT_LATER(a_done_follows_start, accept, LATENCY, done_o, "result strobe missing")
  `SPCT_ASSERT(a_tag_kept, done_o |-> (tag_out_o == $past(pair_tag_i, LATENCY)), "tag mismatch")
  // Coincident circles always touch
  `SPCT_ASSERT_LATER(a_cc_same_center, cc_same, LATENCY, hit_o, "coincident circles missed")
  // Coincident boxes always overlap
  `SPCT_ASSERT_LATER(a_rr_same_center, rr_same, LATENCY, hit_o, "coincident boxes missed")

endmodule
